@@ rtl/hbm_pkg.sv @@
package hbm_pkg;

  localparam int unsigned DEPTH_DEFAULT = 16;

  typedef enum logic [2:0] {
    REQ_START = 3'd0,
    REQ_JOIN  = 3'd1,
    REQ_REPLY = 3'd2,
    REQ_GOSS  = 3'd3,
    REQ_TICK  = 3'd4
  } req_t;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_ADDED   = 3'd1,
    EV_UPDATED = 3'd2,
    EV_STALE   = 3'd3,
    EV_FULL    = 3'd4,
    EV_REMOVED = 3'd5,
    EV_KEPT    = 3'd6,
    EV_EMPTY   = 3'd7
  } ev_t;

  typedef enum logic [2:0] {
    CFG_TIMEOUT = 3'd0,
    CFG_SELF_ID = 3'd1,
    CFG_SELF_PORT = 3'd2,
    CFG_INTRO_ID = 3'd3,
    CFG_INTRO_PORT = 3'd4
  } cfg_t;

  // controller -> datapath
  typedef struct packed {
    logic       load;      // capture input item
    logic       scan_clr;  // reset scan index
    logic       scan_step; // advance scan index
    logic       own_upd;   // raise own heartbeat
    logic       do_ins;    // append key entry
    logic       do_upd;    // update found entry with gossip
    logic       self_key;  // search key is self
    logic       chk_step;  // tick check pass: look for a surviving entry
    logic       sweep_step;// tick sweep: compact current entry, emit it if any entry is kept
    logic       sweep_end; // commit new count
    logic       emit;      // load output register with single result
    logic [2:0] ev;
    logic       ev_from_entry; // output fields from found entry
    logic       ev_zero;       // output fields zero
    logic       ev_self;       // intro start: self with zeros
    logic       set_group;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic       scan_done;  // scan index reached count
    logic       hit;        // current entry matches key
    logic       full;
    logic       intro;
    logic       stale;
    logic       newer;
    logic       in_group;
    logic       out_busy;
    logic       sweep_done;
    logic       sweep_empty;
    logic [2:0] req;
  } sts_t;

endpackage

@@ rtl/hbm_ctrl.sv @@
module hbm_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  hbm_pkg::sts_t sts,
  output hbm_pkg::cmd_t cmd
);
  import hbm_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_SCAN  = 8'b00000010,
    S_ACT   = 8'b00000100,
    S_OWN   = 8'b00001000,
    S_CHK   = 8'b00010000,
    S_SWEEP = 8'b00100000,
    S_FIN   = 8'b01000000,
    S_WAIT  = 8'b10000000
  } state_t;

  state_t state, state_next;
  logic found, found_next;

  assign in_stall = (state != S_IDLE) || sts.out_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      found <= 1'b0;
    end else begin
      state <= state_next;
      found <= found_next;
    end
  end

  always_comb begin
    state_next = state;
    found_next = found;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (in_valid && !sts.out_busy) begin
          cmd.load = 1'b1;
          cmd.scan_clr = 1'b1;
          found_next = 1'b0;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.self_key = (sts.req == REQ_START) || (sts.req == REQ_TICK);
        if (sts.req == REQ_TICK) begin
          if (!sts.in_group) begin
            cmd.emit = 1'b1;
            cmd.ev = EV_NONE;
            cmd.ev_zero = 1'b1;
            state_next = S_WAIT;
          end else if (sts.scan_done || sts.hit) begin
            found_next = sts.hit;
            state_next = S_OWN;
          end else begin
            cmd.scan_step = 1'b1;
          end
        end else if (sts.req == REQ_START && sts.intro) begin
          cmd.emit = 1'b1;
          cmd.ev_self = 1'b1;
          cmd.ev = EV_NONE;
          cmd.set_group = 1'b1;
          state_next = S_WAIT;
        end else if (sts.req == REQ_GOSS && sts.stale) begin
          cmd.emit = 1'b1;
          cmd.ev = EV_STALE;
          state_next = S_WAIT;
        end else if (sts.req > REQ_TICK) begin
          cmd.emit = 1'b1;
          cmd.ev = EV_NONE;
          cmd.ev_zero = 1'b1;
          state_next = S_WAIT;
        end else if (sts.scan_done || sts.hit) begin
          found_next = sts.hit;
          state_next = S_ACT;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_ACT: begin
        cmd.self_key = (sts.req == REQ_START);
        cmd.emit = 1'b1;
        cmd.set_group = (sts.req == REQ_REPLY);
        if (found) begin
          if (sts.req == REQ_GOSS && sts.newer) begin
            cmd.do_upd = 1'b1;
            cmd.ev = EV_UPDATED;
          end else begin
            cmd.ev = EV_NONE;
            cmd.ev_from_entry = 1'b1;
          end
        end else if (sts.full) begin
          cmd.ev = EV_FULL;
        end else begin
          cmd.do_ins = 1'b1;
          cmd.ev = EV_ADDED;
        end
        state_next = S_WAIT;
      end
      S_OWN: begin
        cmd.own_upd = 1'b1;
        cmd.scan_clr = 1'b1;
        state_next = S_CHK;
      end
      // a sweep that removes everything reports only the empty event
      S_CHK: begin
        if (sts.scan_done) begin
          cmd.scan_clr = 1'b1;
          state_next = S_SWEEP;
        end else begin
          cmd.chk_step = 1'b1;
        end
      end
      S_SWEEP: begin
        if (sts.sweep_done) begin
          cmd.sweep_end = 1'b1;
          state_next = S_FIN;
        end else if (!sts.out_busy) begin
          cmd.sweep_step = 1'b1;
        end
      end
      S_FIN: begin
        if (!sts.out_busy) begin
          if (sts.sweep_empty) begin
            cmd.emit = 1'b1;
            cmd.ev = EV_EMPTY;
            cmd.ev_zero = 1'b1;
          end
          state_next = S_WAIT;
        end
      end
      S_WAIT: begin
        if (!sts.out_busy) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

@@ rtl/hbm_dp.sv @@
module hbm_dp #(
  parameter int unsigned TABLE_DEPTH = hbm_pkg::DEPTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  hbm_pkg::cmd_t       cmd,
  output hbm_pkg::sts_t       sts,
  input  logic                cfg_valid,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  logic [2:0]          req_type,
  input  logic [31:0]         member_id,
  input  logic [15:0]         member_port,
  input  logic [31:0]         member_heartbeat,
  input  logic [31:0]         member_timestamp,
  input  logic [31:0]         current_time,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [2:0]          event_res,
  output logic [31:0]         entry_id,
  output logic [15:0]         entry_port,
  output logic [31:0]         entry_heartbeat,
  output logic [31:0]         entry_timestamp,
  output logic                reply_needed,
  output logic                in_group_now,
  output logic                last
);
  import hbm_pkg::*;

  localparam int unsigned IW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  logic [15:0] remove_timeout;
  logic [31:0] self_id, introducer_id;
  logic [15:0] self_port, introducer_port;

  logic [31:0] ids [TABLE_DEPTH];
  logic [15:0] ports [TABLE_DEPTH];
  logic [31:0] hbs [TABLE_DEPTH];
  logic [31:0] stamps [TABLE_DEPTH];

  logic [CW-1:0] count, scan, wr;
  logic [31:0]   own_hb;
  logic          in_group;
  logic          keep_any;
  logic [2:0]    req;
  logic [31:0]   r_id, r_hb, r_ts, now;
  logic [15:0]   r_port;
  logic [IW-1:0] fidx;

  logic [31:0] key_id;
  logic [15:0] key_port;
  logic [IW-1:0] si, wi;
  logic [32:0] stale_sum;
  logic [31:0] age;
  logic expired;
  logic sweep_out;
  // remembers whether the own entry was found during the tick scan
  logic sts_found_q;

  assign si = scan[IW-1:0];
  assign wi = wr[IW-1:0];
  assign key_id = cmd.self_key ? self_id : r_id;
  assign key_port = cmd.self_key ? self_port : r_port;
  assign stale_sum = {1'b0, r_ts} + {17'd0, remove_timeout};
  assign age = (now >= stamps[si]) ? now - stamps[si] : 32'd0;
  assign expired = age >= {16'd0, remove_timeout};
  assign sweep_out = cmd.sweep_step && keep_any;

  always_comb begin
    sts = '0;
    sts.scan_done = (scan >= count);
    sts.hit = (scan < count) && ids[si] == key_id && ports[si] == key_port;
    sts.full = (count >= CW'(TABLE_DEPTH));
    sts.intro = (self_id == introducer_id) && (self_port == introducer_port);
    sts.stale = stale_sum < {1'b0, now};
    sts.newer = hbs[fidx] < r_hb;
    sts.in_group = in_group;
    sts.out_busy = out_valid && out_stall;
    sts.sweep_done = (scan >= count);
    sts.sweep_empty = (count == '0);
    sts.req = req;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      remove_timeout <= 16'd20;
      self_id <= '0;
      self_port <= '0;
      introducer_id <= 32'd1;
      introducer_port <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_TIMEOUT:    remove_timeout <= cfg_data[15:0];
        CFG_SELF_ID:    self_id <= cfg_data;
        CFG_SELF_PORT:  self_port <= cfg_data[15:0];
        CFG_INTRO_ID:   introducer_id <= cfg_data;
        CFG_INTRO_PORT: introducer_port <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req <= req_type;
      r_id <= member_id;
      r_port <= member_port;
      r_hb <= member_heartbeat;
      r_ts <= member_timestamp;
      now <= current_time;
    end
    if (sts.hit) fidx <= si;
    if (cmd.do_ins) begin
      ids[count[IW-1:0]] <= key_id;
      ports[count[IW-1:0]] <= key_port;
      hbs[count[IW-1:0]] <= '0;
      stamps[count[IW-1:0]] <= now;
    end
    if (cmd.do_upd) begin
      hbs[fidx] <= r_hb;
      stamps[fidx] <= now;
    end
    if (cmd.own_upd && sts_found_q) begin
      hbs[fidx] <= own_hb + 32'd1;
      stamps[fidx] <= now;
    end
    // compaction: kept entries move down to the write index
    if (cmd.sweep_step && !expired) begin
      ids[wi] <= ids[si];
      ports[wi] <= ports[si];
      hbs[wi] <= hbs[si];
      stamps[wi] <= stamps[si];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) sts_found_q <= 1'b0;
    else if (cmd.scan_clr && cmd.load) sts_found_q <= 1'b0;
    else if (sts.hit && !cmd.own_upd) sts_found_q <= 1'b1;
    else if (cmd.own_upd) sts_found_q <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      scan <= '0;
      wr <= '0;
      own_hb <= '0;
      in_group <= 1'b0;
      keep_any <= 1'b0;
    end else begin
      if (cmd.scan_clr) begin
        scan <= '0;
        wr <= '0;
      end else if (cmd.scan_step || cmd.chk_step || cmd.sweep_step) begin
        scan <= scan + CW'(1);
      end
      if (cmd.sweep_step && !expired) wr <= wr + CW'(1);
      if (cmd.own_upd) own_hb <= own_hb + 32'd1;
      if (cmd.own_upd) keep_any <= 1'b0;
      else if (cmd.chk_step && !expired) keep_any <= 1'b1;
      if (cmd.do_ins) count <= count + CW'(1);
      if (cmd.sweep_end) count <= wr;
      if (cmd.set_group) in_group <= 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit || sweep_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sweep_out) begin
      event_res <= expired ? EV_REMOVED : EV_KEPT;
      entry_id <= ids[si];
      entry_port <= ports[si];
      entry_heartbeat <= hbs[si];
      entry_timestamp <= stamps[si];
      reply_needed <= 1'b0;
      in_group_now <= in_group;
      // final when this is the last entry and something is kept
      last <= (scan + CW'(1) >= count) && ((wr != '0) || !expired);
    end else if (cmd.emit) begin
      event_res <= cmd.ev;
      reply_needed <= (req == REQ_JOIN) && !cmd.ev_zero && !cmd.ev_self;
      in_group_now <= in_group || cmd.set_group;
      last <= 1'b1;
      if (cmd.ev_zero) begin
        entry_id <= '0;
        entry_port <= '0;
        entry_heartbeat <= '0;
        entry_timestamp <= '0;
      end else if (cmd.ev_self) begin
        entry_id <= self_id;
        entry_port <= self_port;
        entry_heartbeat <= '0;
        entry_timestamp <= '0;
      end else if (cmd.ev_from_entry) begin
        entry_id <= key_id;
        entry_port <= key_port;
        entry_heartbeat <= hbs[fidx];
        entry_timestamp <= stamps[fidx];
      end else if (cmd.ev == EV_STALE) begin
        entry_id <= r_id;
        entry_port <= r_port;
        entry_heartbeat <= r_hb;
        entry_timestamp <= r_ts;
      end else if (cmd.ev == EV_UPDATED) begin
        entry_id <= r_id;
        entry_port <= r_port;
        entry_heartbeat <= r_hb;
        entry_timestamp <= now;
      end else begin
        entry_id <= key_id;
        entry_port <= key_port;
        entry_heartbeat <= '0;
        entry_timestamp <= now;
      end
    end
  end

endmodule

@@ rtl/heartbeat_membership_table_unit.sv @@
// channel | direction | handshake            | payload
// in      | input     | in_valid / in_stall  | req_type, member_*, current_time
// out     | output    | out_valid / out_stall| event_res, entry_*, reply_needed,
//         |           |                      | in_group_now, last
// cfg     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// one item at a time: the table search visits one entry per cycle. start, join,
// reply and gossip items search the table before they act; stale gossip,
// introducer start, unknown codes and an out-of-group tick give a result
// without a search. a tick in the group does an own search, an expiry check
// pass, then the sweep: one result per entry if any entry is kept, else only
// the empty event. rst is synchronous; it empties the table and clears group
// membership. in_stall is high until the last result leaves.
module heartbeat_membership_table_unit #(
  parameter int unsigned TABLE_DEPTH = hbm_pkg::DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  req_type,
  input  logic [31:0] member_id,
  input  logic [15:0] member_port,
  input  logic [31:0] member_heartbeat,
  input  logic [31:0] member_timestamp,
  input  logic [31:0] current_time,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  event_res,
  output logic [31:0] entry_id,
  output logic [15:0] entry_port,
  output logic [31:0] entry_heartbeat,
  output logic [31:0] entry_timestamp,
  output logic        reply_needed,
  output logic        in_group_now,
  output logic        last
);
  import hbm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  hbm_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .sts(sts), .cmd(cmd)
  );

  hbm_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .req_type(req_type), .member_id(member_id), .member_port(member_port),
    .member_heartbeat(member_heartbeat), .member_timestamp(member_timestamp),
    .current_time(current_time),
    .out_valid(out_valid), .out_stall(out_stall), .event_res(event_res),
    .entry_id(entry_id), .entry_port(entry_port),
    .entry_heartbeat(entry_heartbeat), .entry_timestamp(entry_timestamp),
    .reply_needed(reply_needed), .in_group_now(in_group_now), .last(last)
  );

endmodule
